// ===== sv/wfst_pkg.sv =====
`timescale 1ns / 1ps

package wfst_pkg;

	// Station table geometry
	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	// Field widths
	localparam int FC_W    = 16;
	localparam int MAC_W   = 48;
	localparam int LEVEL_W = 8;
	localparam int TIME_W  = 32;
	localparam int KIND_W  = 2;
	localparam int SUB_W   = 4;
	localparam int SLOT_W  = 6;
	localparam int TOTAL_W = 7;
	localparam int FRAMES_W = 32;

	// Frame types and subtypes of interest
	localparam logic [KIND_W-1:0] KIND_MGMT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DATA = 2'd2;
	localparam logic [SUB_W-1:0] SUB_ASSOC_REQ  = 4'd0;
	localparam logic [SUB_W-1:0] SUB_PROBE_REQ  = 4'd4;
	localparam logic [SUB_W-1:0] SUB_PROBE_RESP = 4'd5;
	localparam logic [SUB_W-1:0] SUB_DEAUTH     = 4'd12;

	typedef enum logic [1:0] {
		OUT_NONE    = 2'd0,
		OUT_UPDATED = 2'd1,
		OUT_ADDED   = 2'd2,
		OUT_FULL    = 2'd3
	} outcome_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// Report a table index in the low bits of the slot field
	function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
		logic [IDX_W+SLOT_W-1:0] wide;
		wide = {{SLOT_W{1'b0}}, idx};
		return wide[SLOT_W-1:0];
	endfunction

	// Report a station count in the low bits of the total field
	function automatic logic [TOTAL_W-1:0] to_total(input logic [CNT_W-1:0] cnt);
		logic [CNT_W+TOTAL_W-1:0] wide;
		wide = {{TOTAL_W{1'b0}}, cnt};
		return wide[TOTAL_W-1:0];
	endfunction

endpackage

// ===== sv/wlan_frame_station_tracker.sv =====
`timescale 1ns / 1ps

// Tracks stations seen in received 802.11 frames. One frame is taken per transfer and
// gives exactly one result transfer. Every frame is counted and its type and subtype
// decoded; probe requests and responses and all data frames are looked up by source
// MAC in a 64-entry station table held in synchronous RAM. A known station gets its
// signal level and last-seen time refreshed, a new one is appended with its BSSID, and
// when the table is full the frame leaves the table untouched. The lookup reads one
// occupied entry per cycle and compares it in the following cycle. A frame that matches
// an entry ends its scan at that entry; a frame that appends first scans every held
// station, and the scan is skipped for untracked frames and frames that find the table
// full. The result appears in the same cycle that the next frame can be taken. A result
// waits in an output register, so the next frame is taken and worked while the previous
// result is stalled; only its own result then waits for the register.

module wlan_frame_station_tracker
	import wfst_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [FC_W-1:0]            frame_control,
	input  logic [MAC_W-1:0]           source_mac,
	input  logic [MAC_W-1:0]           bss_id,
	input  logic signed [LEVEL_W-1:0]  signal_level,
	input  logic [TIME_W-1:0]          now_ms,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [KIND_W-1:0]          frame_kind,
	output logic [SUB_W-1:0]           frame_sub,
	output logic [1:0]                 outcome,
	output logic [SLOT_W-1:0]          slot,
	output logic [TOTAL_W-1:0]         station_total,
	output logic [FRAMES_W-1:0]        frames_seen,
	output logic                       log_mark
);

	// Station table memories
	logic [MAC_W-1:0]   mac_mem   [TABLE_DEPTH];
	logic [MAC_W-1:0]   bss_mem   [TABLE_DEPTH];
	logic [LEVEL_W-1:0] level_mem [TABLE_DEPTH];
	logic [TIME_W-1:0]  seen_mem  [TABLE_DEPTH];

	state_t state_q, state_nxt;

	logic [CNT_W-1:0]    count_q;
	logic [FRAMES_W-1:0] frame_cnt_q;
	logic [CNT_W-1:0]    addr_q;

	// Latched frame
	logic [KIND_W-1:0]  kind_q;
	logic [SUB_W-1:0]   sub_q;
	logic [MAC_W-1:0]   mac_q;
	logic [MAC_W-1:0]   bss_q;
	logic [LEVEL_W-1:0] level_q;
	logic [TIME_W-1:0]  now_q;
	outcome_t           res_q;
	logic [IDX_W-1:0]   res_idx_q;

	// Read pipeline
	logic               rd_pend_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic [MAC_W-1:0]   rd_mac_s1;

	// Output register
	logic                out_valid_q;
	logic [KIND_W-1:0]   kind_out_q;
	logic [SUB_W-1:0]    sub_out_q;
	outcome_t            outcome_out_q;
	logic [SLOT_W-1:0]   slot_out_q;
	logic [TOTAL_W-1:0]  total_out_q;
	logic [FRAMES_W-1:0] frames_out_q;
	logic                log_out_q;

	// Control strobes
	logic in_accept;
	logic issue;
	logic hit;
	logic append;
	logic load_out;
	logic out_free;

	// Decode of the incoming frame
	logic [KIND_W-1:0] in_kind;
	logic [SUB_W-1:0]  in_sub;
	logic              in_tracked;
	logic              table_full;

	assign in_kind = frame_control[3:2];
	assign in_sub  = frame_control[7:4];
	assign in_tracked = (in_kind == KIND_DATA) ||
		((in_kind == KIND_MGMT) && ((in_sub == SUB_PROBE_REQ) || (in_sub == SUB_PROBE_RESP)));
	assign table_full = (count_q >= CNT_W'(TABLE_DEPTH));

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;

	// Next state and strobes
	always_comb begin
		state_nxt = state_q;
		issue     = 1'b0;
		hit       = 1'b0;
		append    = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = (in_tracked && !table_full) ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				issue = (addr_q < count_q);
				if (rd_pend_s1 && (rd_mac_s1 == mac_q)) begin
					hit       = 1'b1;
					issue     = 1'b0;
					state_nxt = ST_DONE;
				end else if (!rd_pend_s1 && !issue) begin
					append    = 1'b1;
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					load_out  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Counters and scan address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			frame_cnt_q <= '0;
			addr_q      <= '0;
			rd_pend_s1  <= 1'b0;
			res_q       <= OUT_NONE;
		end else begin
			if (in_accept) begin
				frame_cnt_q <= frame_cnt_q + 1'b1;
				addr_q      <= '0;
				rd_pend_s1  <= 1'b0;
				if (!in_tracked) begin
					res_q <= OUT_NONE;
				end else if (table_full) begin
					res_q <= OUT_FULL;
				end
			end else if (state_q == ST_SCAN) begin
				rd_pend_s1 <= issue;
				if (issue) begin
					addr_q <= addr_q + 1'b1;
				end
			end
			if (hit) begin
				res_q <= OUT_UPDATED;
			end
			if (append) begin
				res_q   <= OUT_ADDED;
				count_q <= count_q + 1'b1;
			end
		end
	end

	// Hold the frame under work
	always_ff @(posedge clk) begin
		if (in_accept) begin
			kind_q    <= in_kind;
			sub_q     <= in_sub;
			mac_q     <= source_mac;
			bss_q     <= bss_id;
			level_q   <= signal_level;
			now_q     <= now_ms;
			res_idx_q <= '0;
		end
		if (hit) begin
			res_idx_q <= rd_idx_s1;
		end
		if (append) begin
			res_idx_q <= count_q[IDX_W-1:0];
		end
	end

	// Read one MAC entry per scan cycle
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_mac_s1 <= mac_mem[addr_q[IDX_W-1:0]];
			rd_idx_s1 <= addr_q[IDX_W-1:0];
		end
	end

	// Write back: append a new station, refresh a known one
	always_ff @(posedge clk) begin
		if (append) begin
			mac_mem[count_q[IDX_W-1:0]] <= mac_q;
			bss_mem[count_q[IDX_W-1:0]] <= bss_q;
		end
		if (append) begin
			level_mem[count_q[IDX_W-1:0]] <= level_q;
			seen_mem[count_q[IDX_W-1:0]]  <= now_q;
		end else if (hit) begin
			level_mem[rd_idx_s1] <= level_q;
			seen_mem[rd_idx_s1]  <= now_q;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			kind_out_q    <= kind_q;
			sub_out_q     <= sub_q;
			outcome_out_q <= res_q;
			slot_out_q    <= ((res_q == OUT_UPDATED) || (res_q == OUT_ADDED)) ?
				to_slot(res_idx_q) : '0;
			total_out_q   <= to_total(count_q);
			frames_out_q  <= frame_cnt_q;
			log_out_q     <= (kind_q == KIND_MGMT) &&
				((sub_q == SUB_ASSOC_REQ) || (sub_q == SUB_DEAUTH));
		end
	end

	assign out_valid     = out_valid_q;
	assign frame_kind    = kind_out_q;
	assign frame_sub     = sub_out_q;
	assign outcome       = outcome_out_q;
	assign slot          = slot_out_q;
	assign station_total = total_out_q;
	assign frames_seen   = frames_out_q;
	assign log_mark      = log_out_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("station count beyond table depth");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		append |=> (count_q == $past(count_q) + 1'b1))
		else $error("append did not grow the table by one");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		hit |-> ({1'b0, rd_idx_s1} < {1'b0, count_q}))
		else $error("match on an unoccupied entry");

	a_frame_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (frame_cnt_q == $past(frame_cnt_q) + 1'b1))
		else $error("frame counter did not advance on transfer");

	a_full_untouched: assert property (@(posedge clk) disable iff (!arst_n)
		(table_full && state_q != ST_SCAN) |-> (!append && !hit))
		else $error("table written while full");

endmodule
